// ===== design/tft_pkg.sv =====
package tft_pkg;

  localparam int COORD_FRAC_BITS   = 16;
  localparam int TANGENT_FRAC_BITS = 14;

  localparam int COORD_W = 32;
  localparam int TAN_W   = 16;
  localparam int CFG_W   = 32;
  localparam int DELTA_W = COORD_W + 1;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int NORM_W  = 31;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;

  localparam logic [CFG_W-1:0] THR_RESET = CFG_W'(4295);

  localparam int THR_SHL_MAG = (2 * COORD_FRAC_BITS <= 32) ? 32 - 2 * COORD_FRAC_BITS : 0;
  localparam int THR_SHL_THR = (2 * COORD_FRAC_BITS > 32) ? 2 * COORD_FRAC_BITS - 32 : 0;
  localparam int CMP_W       = ACC_W + 32;

  localparam int QUO_W = TANGENT_FRAC_BITS + 2;
  localparam int NUM_W = NORM_W + TANGENT_FRAC_BITS + 1;

endpackage

// ===== design/tft_vertex_if.sv =====
interface tft_vertex_if;
  import tft_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] tex_u;
  logic signed [COORD_W-1:0] tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// ===== design/tft_tangent_if.sv =====
interface tft_tangent_if;
  import tft_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TAN_W-1:0] tan_x;
  logic signed [TAN_W-1:0] tan_y;
  logic signed [TAN_W-1:0] tan_z;
  logic                    last_of_triangle;
  logic                    degenerate_uv;
  logic                    zero_tangent;

  modport source (output valid, tan_x, tan_y, tan_z, last_of_triangle, degenerate_uv,
                  zero_tangent, input ready);
  modport sink (input valid, tan_x, tan_y, tan_z, last_of_triangle, degenerate_uv,
                zero_tangent, output ready);
endinterface

// ===== design/triangle_tangent_from_uv.sv =====
// triangle_tangent_from_uv: per-triangle unit tangent from texture coordinates
// in_i takes one vertex per transaction (Q16.16 position and uv). The first two
// vertices of a triangle are stored and give no result.
// The third vertex starts the computation on one shared 33x33 multiplier
// and one shared add/compare unit under a sequencer, in these steps:
//   determinant and raw tangent products,
//   one-bit normalizing shifts,
//   sum of squares, square root,
//   restoring division for each of the three components.
// A zero-length tangent skips from normalizing straight to the output; in_i
// is not ready from the third vertex until the last result has been taken.
// out_o then gives the same Q1.14 tangent in three transactions, the third
// with last_of_triangle set; a stalled out_o simply holds the result.
// cfg_we_i writes degenerate_threshold; write it only while the block is idle.
// Reset clears the vertex count (next vertex starts a triangle), returns the
// threshold to 4295 and drops out_o.valid.
module triangle_tangent_from_uv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tft_vertex_if.sink                in_i,
  tft_tangent_if.source             out_o,
  input  logic                      cfg_we_i,
  input  logic [tft_pkg::CFG_W-1:0] cfg_wdata_i
);
  import tft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_NORM, S_SQ, S_SQRT, S_DIV, S_OUT
  } state_e;

  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(8);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W + 1);

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       lane_q;
  logic [1:0]       vslot_q;
  logic [1:0]       out_idx_q;
  logic             out_valid_q;
  logic             last_q;
  logic [CFG_W-1:0] thr_q;

  logic signed [COORD_W-1:0] p0_q [3];
  logic signed [COORD_W-1:0] p1_q [3];
  logic signed [COORD_W-1:0] u0_q, v0_q, u1_q, v1_q;
  logic signed [DELTA_W-1:0] dp1_q [3];
  logic signed [DELTA_W-1:0] dp2_q [3];
  logic signed [DELTA_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]          mag_q [3];
  logic [2:0]                neg_q;
  logic                      degen_q, flip_q, zero_q;
  logic [SUM_W-1:0]          sum_q, sq_val_q;
  logic [ROOT_W+1:0]         sq_rem_q;
  logic [ROOT_W-1:0]         root_q;
  logic [QUO_W-1:0]          div_n_q;
  logic [ROOT_W:0]           div_r_q;
  logic [QUO_W-1:0]          quo_q;
  logic signed [TAN_W-1:0]   tan_q [3];

  logic                      in_acc, out_acc;
  logic signed [DELTA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   diff;
  logic [ACC_W-1:0]          diff_abs, orv;
  logic [CMP_W-1:0]          cmp_mag, cmp_thr;
  logic                      diff_degen;
  logic [1:0]                comp_idx, sq_idx;
  logic [SUM_W-1:0]          sum_next;
  logic [ROOT_W+3:0]         sq_rem2, sq_trial;
  logic [NUM_W-1:0]          num;
  logic [ROOT_W:0]           div_rs;
  logic [QUO_W-1:0]          quo_clamp, quo_signed;

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid            = out_valid_q;
  assign out_o.tan_x            = tan_q[0];
  assign out_o.tan_y            = tan_q[1];
  assign out_o.tan_z            = tan_q[2];
  assign out_o.last_of_triangle = last_q;
  assign out_o.degenerate_uv    = degen_q;
  assign out_o.zero_tangent     = zero_q;

  // shared multiplier operand select
  assign sq_idx = (cnt_q < SQ_LAST) ? cnt_q[1:0] : 2'd0;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_MUL) begin
      unique case (cnt_q)
        CNT_W'(0): begin mul_a = du1_q; mul_b = dv2_q;    end
        CNT_W'(1): begin mul_a = du2_q; mul_b = dv1_q;    end
        CNT_W'(2): begin mul_a = dv2_q; mul_b = dp1_q[0]; end
        CNT_W'(3): begin mul_a = dv1_q; mul_b = dp2_q[0]; end
        CNT_W'(4): begin mul_a = dv2_q; mul_b = dp1_q[1]; end
        CNT_W'(5): begin mul_a = dv1_q; mul_b = dp2_q[1]; end
        CNT_W'(6): begin mul_a = dv2_q; mul_b = dp1_q[2]; end
        CNT_W'(7): begin mul_a = dv1_q; mul_b = dp2_q[2]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == S_SQ) begin
      mul_a = $signed({{(DELTA_W-NORM_W){1'b0}}, mag_q[sq_idx][NORM_W-1:0]});
      mul_b = mul_a;
    end
  end
  assign mul_p = mul_a * mul_b;

  // shared subtract and threshold compare
  assign diff       = acc_q - {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign diff_abs   = diff[ACC_W-1] ? ACC_W'(-diff) : diff;
  assign cmp_mag    = CMP_W'(diff_abs) << THR_SHL_MAG;
  assign cmp_thr    = CMP_W'(thr_q) << THR_SHL_THR;
  assign diff_degen = (diff == '0) || (cmp_mag < cmp_thr);
  assign comp_idx   = 2'((cnt_q >> 1) - CNT_W'(2));

  assign orv      = mag_q[0] | mag_q[1] | mag_q[2];
  assign sum_next = sum_q + prod_q[SUM_W-1:0];

  assign sq_rem2  = {sq_rem_q, sq_val_q[SUM_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};

  assign num    = (NUM_W'(mag_q[lane_q][NORM_W-1:0]) << TANGENT_FRAC_BITS)
                + NUM_W'(root_q >> 1);
  assign div_rs = {div_r_q[ROOT_W-1:0], div_n_q[QUO_W-1]};

  assign quo_clamp  = (quo_q > QUO_W'(1 << TANGENT_FRAC_BITS)) ?
                      QUO_W'(1 << TANGENT_FRAC_BITS) : quo_q;
  assign quo_signed = (neg_q[lane_q] != flip_q) ? QUO_W'(-quo_clamp) : quo_clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lane_q      <= '0;
      vslot_q     <= '0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      thr_q       <= THR_RESET;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (vslot_q < 2'd2) begin
              vslot_q <= vslot_q + 2'd1;
            end else begin
              vslot_q <= '0;
              cnt_q   <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (cnt_q == MUL_LAST) begin
            state_q <= S_NORM;
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end
        S_NORM: begin
          cnt_q <= '0;
          if (orv == '0) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
            out_idx_q   <= '0;
            last_q      <= 1'b0;
          end else if (orv[ACC_W-1:NORM_W] == '0 && orv[NORM_W-1]) begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_q == SQ_LAST) begin
            state_q <= S_SQRT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_SQRT: begin
          if (cnt_q == SQRT_LAST) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
            lane_q  <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_DIV: begin
          if (cnt_q == DIV_LAST) begin
            cnt_q <= '0;
            if (lane_q == 2'd2) begin
              state_q     <= S_OUT;
              out_valid_q <= 1'b1;
              out_idx_q   <= '0;
              last_q      <= 1'b0;
            end else begin
              lane_q <= lane_q + 2'd1;
            end
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (out_idx_q == 2'd2) begin
              out_valid_q <= 1'b0;
              last_q      <= 1'b0;
              state_q     <= S_IDLE;
            end else begin
              out_idx_q <= out_idx_q + 2'd1;
              last_q    <= (out_idx_q == 2'd1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (vslot_q == 2'd0) begin
            p0_q[0] <= in_i.pos_x;
            p0_q[1] <= in_i.pos_y;
            p0_q[2] <= in_i.pos_z;
            u0_q    <= in_i.tex_u;
            v0_q    <= in_i.tex_v;
          end else if (vslot_q == 2'd1) begin
            p1_q[0] <= in_i.pos_x;
            p1_q[1] <= in_i.pos_y;
            p1_q[2] <= in_i.pos_z;
            u1_q    <= in_i.tex_u;
            v1_q    <= in_i.tex_v;
          end else begin
            for (int i = 0; i < 3; i++) begin
              dp1_q[i] <= DELTA_W'(p1_q[i]) - DELTA_W'(p0_q[i]);
            end
            dp2_q[0] <= DELTA_W'(in_i.pos_x) - DELTA_W'(p0_q[0]);
            dp2_q[1] <= DELTA_W'(in_i.pos_y) - DELTA_W'(p0_q[1]);
            dp2_q[2] <= DELTA_W'(in_i.pos_z) - DELTA_W'(p0_q[2]);
            du1_q    <= DELTA_W'(u1_q) - DELTA_W'(u0_q);
            dv1_q    <= DELTA_W'(v1_q) - DELTA_W'(v0_q);
            du2_q    <= DELTA_W'(in_i.tex_u) - DELTA_W'(u0_q);
            dv2_q    <= DELTA_W'(in_i.tex_v) - DELTA_W'(v0_q);
            zero_q   <= 1'b0;
          end
        end
      end
      S_MUL: begin
        if (cnt_q != '0) begin
          if (cnt_q[0]) begin
            acc_q <= {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
          end else if (cnt_q == CNT_W'(2)) begin
            degen_q <= diff_degen;
            flip_q  <= !diff_degen && diff[ACC_W-1];
          end else begin
            mag_q[comp_idx] <= diff_abs;
            neg_q[comp_idx] <= diff[ACC_W-1];
          end
        end
      end
      S_NORM: begin
        sum_q <= '0;
        if (orv == '0) begin
          zero_q <= 1'b1;
          for (int i = 0; i < 3; i++) tan_q[i] <= '0;
        end else if (orv[ACC_W-1:NORM_W] != '0) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (!orv[NORM_W-1]) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
      end
      S_SQ: begin
        if (cnt_q != '0) sum_q <= sum_next;
        if (cnt_q == SQ_LAST) begin
          sq_val_q <= sum_next;
          sq_rem_q <= '0;
          root_q   <= '0;
        end
      end
      S_SQRT: begin
        sq_val_q <= sq_val_q << 2;
        if (sq_rem2 >= sq_trial) begin
          sq_rem_q <= (ROOT_W+2)'(sq_rem2 - sq_trial);
          root_q   <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_q <= sq_rem2[ROOT_W+1:0];
          root_q   <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          div_r_q <= (ROOT_W+1)'(num[NUM_W-1:QUO_W]);
          div_n_q <= num[QUO_W-1:0];
          quo_q   <= '0;
        end else if (cnt_q == DIV_LAST) begin
          tan_q[lane_q] <= quo_signed[TAN_W-1:0];
        end else begin
          div_n_q <= div_n_q << 1;
          if (div_rs >= {1'b0, root_q}) begin
            div_r_q <= div_rs - {1'b0, root_q};
            quo_q   <= {quo_q[QUO_W-2:0], 1'b1};
          end else begin
            div_r_q <= div_rs;
            quo_q   <= {quo_q[QUO_W-2:0], 1'b0};
          end
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== verif/tb_triangle_tangent_from_uv.sv =====
`timescale 1ns / 100ps

module tb_triangle_tangent_from_uv;
  import tft_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  } vertex_t;

  typedef struct {
    logic signed [TAN_W-1:0] tan_x, tan_y, tan_z;
    logic                    last_of_triangle, degenerate_uv, zero_tangent;
  } tangent_t;

  typedef struct {
    vertex_t  vtx;
    bit       typed;
    tangent_t tan;
  } stim_row_t;

  localparam int Q1 = 65536;
  localparam logic signed [TAN_W-1:0] UNIT = 16'sd16384;
  localparam logic signed [COORD_W-1:0] MAXC = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] MINC = 32'sh80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  tft_vertex_if  vin();
  tft_tangent_if vout();

  triangle_tangent_from_uv DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (vin),
    .out_o       (vout),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  tangent_t   tangent_q[$];
  vertex_t    held_vtx[2];
  int         slot_cnt = 0;
  logic [CFG_W-1:0] thr_model = THR_RESET;
  int         errors = 0;
  int         rx_count = 0;
  int         idle_cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'h1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic int bit_length(logic signed [127:0] a);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (a[i]) n = i + 1;
    return n;
  endfunction

  function automatic tangent_t triangle_tangent(vertex_t a, vertex_t b, vertex_t c);
    logic signed [127:0] dp1[3], dp2[3], comp[3], mag[3];
    logic signed [127:0] du1, dv1, du2, dv2, det, adet;
    logic [63:0] m[3], sum, l, v;
    logic [TAN_W-1:0] q[3];
    bit degen, flip, zero;
    int len, bl;
    tangent_t t;
    dp1[0] = 128'(a.pos_x); dp1[1] = 128'(a.pos_y); dp1[2] = 128'(a.pos_z);
    dp1[0] = 128'(b.pos_x) - dp1[0];
    dp1[1] = 128'(b.pos_y) - dp1[1];
    dp1[2] = 128'(b.pos_z) - dp1[2];
    dp2[0] = 128'(c.pos_x) - 128'(a.pos_x);
    dp2[1] = 128'(c.pos_y) - 128'(a.pos_y);
    dp2[2] = 128'(c.pos_z) - 128'(a.pos_z);
    du1 = 128'(b.tex_u) - 128'(a.tex_u);
    dv1 = 128'(b.tex_v) - 128'(a.tex_v);
    du2 = 128'(c.tex_u) - 128'(a.tex_u);
    dv2 = 128'(c.tex_v) - 128'(a.tex_v);
    det = du1 * dv2 - du2 * dv1;
    adet = det < 0 ? -det : det;
    degen = (det == 0) || (adet < $signed({96'b0, thr_model}));
    flip = !degen && det < 0;
    len = 0;
    zero = 1;
    for (int i = 0; i < 3; i++) begin
      comp[i] = dv2 * dp1[i] - dv1 * dp2[i];
      mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
      bl = bit_length(mag[i]);
      if (bl > len) len = bl;
      if (bl != 0) zero = 0;
    end
    for (int i = 0; i < 3; i++) q[i] = '0;
    if (!zero) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = len > 31 ? 64'(mag[i] >> (len - 31)) : 64'(mag[i] << (31 - len));
        sum += m[i] * m[i];
      end
      l = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        v = ((m[i] << TANGENT_FRAC_BITS) + (l >> 1)) / l;
        if (v > (64'h1 << TANGENT_FRAC_BITS)) v = 64'h1 << TANGENT_FRAC_BITS;
        if ((comp[i] < 0) != flip) v = -v;
        q[i] = v[TAN_W-1:0];
      end
    end
    t.tan_x = q[0];
    t.tan_y = q[1];
    t.tan_z = q[2];
    t.last_of_triangle = 0;
    t.degenerate_uv = degen;
    t.zero_tangent = zero;
    return t;
  endfunction

  // advances the vertex count; returns 1 on the third vertex
  function automatic bit take_vertex(vertex_t v, output tangent_t t);
    if (slot_cnt < 2) begin
      held_vtx[slot_cnt] = v;
      slot_cnt++;
      return 0;
    end
    slot_cnt = 0;
    t = triangle_tangent(held_vtx[0], held_vtx[1], v);
    return 1;
  endfunction

  function automatic void push_triangle(tangent_t t);
    for (int k = 0; k < 3; k++) begin
      t.last_of_triangle = (k == 2);
      tangent_q.insert(tangent_q.size(), t);
    end
  endfunction

  function automatic vertex_t mk_vtx(int px, int py, int pz, int u, int v);
    vertex_t r;
    r.pos_x = px; r.pos_y = py; r.pos_z = pz; r.tex_u = u; r.tex_v = v;
    return r;
  endfunction

  function automatic tangent_t mk_tan(int x, int y, int z, bit dg, bit zr);
    tangent_t r;
    r.tan_x = TAN_W'(x); r.tan_y = TAN_W'(y); r.tan_z = TAN_W'(z);
    r.last_of_triangle = 0; r.degenerate_uv = dg; r.zero_tangent = zr;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: case ($urandom_range(0, 3))
           0: return MAXC;
           1: return MINC;
           2: return 32'hffffffff;
           default: return 32'h0;
         endcase
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) << 8;
    endcase
  endfunction

  task automatic send_vertex(vertex_t v, int gap);
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vin.valid <= 1'b1;
    vin.pos_x <= v.pos_x;
    vin.pos_y <= v.pos_y;
    vin.pos_z <= v.pos_z;
    vin.tex_u <= v.tex_u;
    vin.tex_v <= v.tex_v;
    do @(posedge clk_i); while (!vin.ready);
    @(negedge clk_i);
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic drain_and_write(logic [CFG_W-1:0] val);
    vin.valid <= 1'b0;
    while (tangent_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    thr_model = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_vertex(vertex_t v, bit typed, tangent_t typed_tan, int gap);
    tangent_t t;
    if (take_vertex(v, t)) push_triangle(typed ? typed_tan : t);
    send_vertex(v, gap);
  endtask

  stim_row_t directed[$];

  task automatic add_row(vertex_t v, bit typed, tangent_t t);
    stim_row_t r;
    r.vtx = v;
    r.typed = typed;
    r.tan = t;
    directed.insert(directed.size(), r);
  endtask

  task automatic build_directed();
    tangent_t none;
    none = mk_tan(0, 0, 0, 0, 0);
    // axis-aligned unit case
    add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
    add_row(mk_vtx(Q1, 0, 0, Q1, 0), 0, none);
    add_row(mk_vtx(0, Q1, 0, 0, Q1), 1, mk_tan(UNIT, 0, 0, 0, 0));
    // all zero: degenerate and zero length
    add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
    add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
    add_row(mk_vtx(0, 0, 0, 0, 0), 1, mk_tan(0, 0, 0, 1, 1));
    // negative determinant flips sign
    add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
    add_row(mk_vtx(Q1, 0, 0, 0, Q1), 0, none);
    add_row(mk_vtx(0, Q1, 0, Q1, 0), 1, mk_tan(0, UNIT, 0, 0, 0));
    // tiny determinant below threshold
    add_row(mk_vtx(0, 0, 0, 0, 0), 0, none);
    add_row(mk_vtx(0, 0, -Q1, 1, 0), 0, none);
    add_row(mk_vtx(Q1, Q1, 0, 1, 1), 1, mk_tan(0, 0, -UNIT, 1, 0));
    // extremes
    add_row(mk_vtx(MINC, MINC, MINC, MINC, MINC), 0, none);
    add_row(mk_vtx(MAXC, MAXC, MAXC, MAXC, MINC), 0, none);
    add_row(mk_vtx(MINC, MAXC, MINC, MINC, MAXC), 0, none);
    add_row(mk_vtx(MAXC, MINC, 0, MAXC, MAXC), 0, none);
    add_row(mk_vtx(MINC, MAXC, -1, MINC, MINC), 0, none);
    add_row(mk_vtx(-1, -1, MAXC, MAXC, MINC), 0, none);
    // collinear uv, same positions: zero tangent not degenerate-only
    add_row(mk_vtx(5, 5, 5, 0, 0), 0, none);
    add_row(mk_vtx(5, 5, 5, Q1, Q1), 0, none);
    add_row(mk_vtx(5, 5, 5, 2 * Q1, 2 * Q1), 1, mk_tan(0, 0, 0, 1, 1));
  endtask

  task automatic random_triangles(int count);
    vertex_t v[3];
    int mode, kind;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        v[k].pos_x = rand_coord(mode);
        v[k].pos_y = rand_coord(mode);
        v[k].pos_z = rand_coord(mode);
        v[k].tex_u = rand_coord($urandom_range(0, 3));
        v[k].tex_v = rand_coord($urandom_range(0, 3));
      end
      if (kind == 0) begin
        v[1].tex_u = v[0].tex_u + $urandom_range(0, 3);
        v[1].tex_v = v[0].tex_v;
        v[2].tex_u = v[0].tex_u;
        v[2].tex_v = v[0].tex_v + $urandom_range(0, 3);
      end else if (kind == 1) begin
        v[2] = v[0];
      end
      for (int k = 0; k < 3; k++) apply_vertex(v[k], 0, mk_tan(0, 0, 0, 0, 0), sender_gap());
    end
  endtask

  initial begin
    vin.valid = 1'b0;
    vin.pos_x = '0; vin.pos_y = '0; vin.pos_z = '0; vin.tex_u = '0; vin.tex_v = '0;
    build_directed();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) apply_vertex(directed[i].vtx, directed[i].typed, directed[i].tan,
                                       sender_gap());
    random_triangles(27);
    drain_and_write(32'h0);
    random_triangles(27);
    drain_and_write(32'hffffffff);
    random_triangles(27);
    drain_and_write($urandom());
    random_triangles(26);
    drain_and_write(32'($urandom_range(0, 1 << 20)));
    random_triangles(1);
    vin.valid <= 1'b0;
    while (tangent_q.size() != 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("triangle_tangent_from_uv regression: pass");
    end else begin
      $display("triangle_tangent_from_uv regression: fail");
    end
    $finish;
  end

  // receiver with random stalls and one long hold-off
  initial begin : receiver
    bit held_off;
    int r;
    held_off = 0;
    vout.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && rx_count >= 20) begin
        vout.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        held_off = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          vout.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk_i);
        end else if (r < 18) begin
          vout.ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(negedge clk_i);
        end else begin
          vout.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    tangent_t e;
    if (rst_ni && vout.valid && vout.ready) begin
      rx_count++;
      if (tangent_q.size() == 0) begin
        $error("unexpected tangent transaction");
        errors++;
      end else begin
        e = tangent_q.pop_front();
        if (vout.tan_x !== e.tan_x) begin
          $error("tan_x expected %0d actual %0d", e.tan_x, vout.tan_x); errors++;
        end
        if (vout.tan_y !== e.tan_y) begin
          $error("tan_y expected %0d actual %0d", e.tan_y, vout.tan_y); errors++;
        end
        if (vout.tan_z !== e.tan_z) begin
          $error("tan_z expected %0d actual %0d", e.tan_z, vout.tan_z); errors++;
        end
        if (vout.last_of_triangle !== e.last_of_triangle) begin
          $error("last_of_triangle expected %0b actual %0b", e.last_of_triangle,
                 vout.last_of_triangle); errors++;
        end
        if (vout.degenerate_uv !== e.degenerate_uv) begin
          $error("degenerate_uv expected %0b actual %0b", e.degenerate_uv,
                 vout.degenerate_uv); errors++;
        end
        if (vout.zero_tangent !== e.zero_tangent) begin
          $error("zero_tangent expected %0b actual %0b", e.zero_tangent,
                 vout.zero_tangent); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
        $display("triangle_tangent_from_uv regression: fail");
        $finish;
      end
    end
  end

endmodule

// ===== triangle_tangent_from_uv.f =====
design/tft_pkg.sv
design/tft_vertex_if.sv
design/tft_tangent_if.sv
design/triangle_tangent_from_uv.sv
verif/tb_triangle_tangent_from_uv.sv
